### design/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page replacement core: beat
// payloads of the reference and result channels, and the lookup decision.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 3;
    localparam int MISS_W  = 32;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0]  CFG_RESET = 4'd8;
    localparam logic [MISS_W-1:0] MISS_MAX  = '1;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              start_of_string;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_used;
        logic [MISS_W-1:0]  miss_total;
    } out_item_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } lookup_t;

endpackage

`default_nettype wire

### design/lru_page_replacement_core.sv
// A reference beat passes the input stage and then the result register.
// Throughput: one reference per cycle while no result stall holds the input;
// each is looked up and retired in the single cycle it leaves the input stage.
// Reset: all frames empty, all ranks zero, miss count zero, frames_in_use 8,
// both stages empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// LRU page replacement over a small frame table, one page reference per beat,
// with an input stage, a frame table lookup and a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_core #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  lrupr_pkg::in_item_t               in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output lrupr_pkg::out_item_t              out_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lrupr_pkg::CFG_W-1:0]  cfg_data
);

    lrupr_pkg::in_item_t          in_data_reg;
    lrupr_pkg::in_item_t          in_data_next;
    logic                         in_vld_reg;
    logic                         in_vld_next;
    lrupr_pkg::out_item_t         out_data_reg;
    lrupr_pkg::out_item_t         out_data_next;
    logic                         out_vld_reg;
    logic                         out_vld_next;
    logic [lrupr_pkg::MISS_W-1:0] miss_reg;
    logic [lrupr_pkg::MISS_W-1:0] miss_next;
    logic [lrupr_pkg::CFG_W-1:0]  cfg_reg;
    logic [lrupr_pkg::CFG_W-1:0]  cfg_next;

    logic                         advance;
    logic                         in_take;
    logic [PAGE_BITS-1:0]         page;
    logic [lrupr_pkg::MISS_W-1:0] miss_base;
    lrupr_pkg::lookup_t           lookup;

    assign advance   = in_vld_reg & (~out_vld_reg | out_ready);
    assign in_ready  = ~in_vld_reg | advance;
    assign in_take   = in_valid & in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;
    assign page      = PAGE_BITS'(in_data_reg.page_number);

    lrupr_frames #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_frames (
        .clk           (clk),
        .rst_n         (rst_n),
        .upd           (advance),
        .start         (in_data_reg.start_of_string),
        .page          (page),
        .frames_in_use (cfg_reg),
        .lookup        (lookup)
    );

    always_comb
    begin
        miss_base = in_data_reg.start_of_string ? '0 : miss_reg;
        if (lookup.hit || (miss_base == lrupr_pkg::MISS_MAX))
        begin
            miss_next = miss_base;
        end
        else
        begin
            miss_next = miss_base + 1'b1;
        end
        if (!advance)
        begin
            miss_next = miss_reg;
        end
    end

    always_comb
    begin
        in_vld_next  = in_take | (in_vld_reg & ~advance);
        in_data_next = in_take ? in_data : in_data_reg;
        out_vld_next = advance | (out_vld_reg & ~out_ready);
        out_data_next = out_data_reg;
        if (advance)
        begin
            out_data_next.hit        = lookup.hit;
            out_data_next.frame_used = lookup.frame;
            out_data_next.miss_total = miss_next;
        end
        cfg_next = (cfg_valid && cfg_ready) ? cfg_data : cfg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            miss_reg    <= '0;
            cfg_reg     <= lrupr_pkg::CFG_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            miss_reg    <= miss_next;
            cfg_reg     <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

### design/lrupr_frames.sv
// ----------------------------------------------------------------------------
// lrupr_frames
// Frame table: page tags, valid bits and recency ranks. Searches the active
// frames, picks the hit, empty or least recently used frame, and updates
// the ranks when the reference is retired.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_frames #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          upd,
    input  wire logic                          start,
    input  wire logic [PAGE_BITS-1:0]          page,
    input  wire logic [lrupr_pkg::CFG_W-1:0]   frames_in_use,
    output lrupr_pkg::lookup_t                 lookup
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [PAGE_BITS-1:0] page_reg [FRAMES];
    logic [FRAMES-1:0]    valid_reg;
    logic [FRAMES-1:0]    valid_next;
    logic [IDX_W-1:0]     rank_reg  [FRAMES];
    logic [IDX_W-1:0]     rank_next [FRAMES];

    logic [FRAMES-1:0]          eff_valid;
    logic [IDX_W-1:0]           eff_rank [FRAMES];
    logic [lrupr_pkg::CFG_W-1:0] cnt_eff;
    logic [FRAMES-1:0]          active;
    logic [FRAMES-1:0]          match;
    logic [FRAMES-1:0]          empty;
    logic [FRAMES-1:0]          oldest;
    logic [IDX_W-1:0]           hit_idx;
    logic [IDX_W-1:0]           empty_idx;
    logic [IDX_W-1:0]           old_idx;
    logic [IDX_W-1:0]           chosen;
    logic                       hit;
    logic                       sel_valid;
    logic [IDX_W-1:0]           sel_rank;

    // Clear state ahead of a reference that opens a new string, and mark the active, matching and empty frames.
    always_comb
    begin
        cnt_eff = (frames_in_use == '0) ? lrupr_pkg::CFG_W'(1) : frames_in_use;
        for (int f = 0; f < FRAMES; f++)
        begin
            eff_valid[f] = start ? 1'b0 : valid_reg[f];
            eff_rank[f]  = start ? '0 : rank_reg[f];
            active[f]    = (f < int'(cnt_eff));
            match[f]     = active[f] & eff_valid[f] & (page_reg[f] == page);
            empty[f]     = active[f] & ~eff_valid[f];
        end
    end

    always_comb
    begin
        for (int f = 0; f < FRAMES; f++)
        begin
            oldest[f] = active[f];
            for (int g = 0; g < FRAMES; g++)
            begin
                if (g != f && active[g] && (eff_rank[g] > eff_rank[f]))
                begin
                    oldest[f] = 1'b0;
                end
            end
        end
    end

    // Pick the lowest-numbered frame of each kind; a hit wins over an empty frame, an empty frame over the oldest.
    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        old_idx   = '0;
        for (int f = FRAMES - 1; f >= 0; f--)
        begin
            if (match[f])
            begin
                hit_idx = IDX_W'(f);
            end
            if (empty[f])
            begin
                empty_idx = IDX_W'(f);
            end
            if (oldest[f])
            begin
                old_idx = IDX_W'(f);
            end
        end
        hit = |match;
        if (hit)
        begin
            chosen = hit_idx;
        end
        else if (|empty)
        begin
            chosen = empty_idx;
        end
        else
        begin
            chosen = old_idx;
        end
        sel_valid = eff_valid[chosen];
        sel_rank  = eff_rank[chosen];
    end

    // Promote the chosen frame; age the frames that were more recent.
    always_comb
    begin
        for (int g = 0; g < FRAMES; g++)
        begin
            rank_next[g]  = eff_rank[g];
            valid_next[g] = eff_valid[g];
            if (IDX_W'(g) == chosen)
            begin
                rank_next[g]  = '0;
                valid_next[g] = 1'b1;
            end
            else if (eff_valid[g] && (!sel_valid || (eff_rank[g] < sel_rank)))
            begin
                rank_next[g] = eff_rank[g] + 1'b1;
            end
        end
    end

    assign lookup.hit   = hit;
    assign lookup.frame = lrupr_pkg::FRAME_W'(chosen);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int g = 0; g < FRAMES; g++)
            begin
                rank_reg[g] <= '0;
            end
        end
        else if (upd)
        begin
            valid_reg <= valid_next;
            for (int g = 0; g < FRAMES; g++)
            begin
                rank_reg[g] <= rank_next[g];
            end
        end
    end

    // Load the page on a miss.
    always_ff @(posedge clk)
    begin
        if (upd && !hit)
        begin
            page_reg[chosen] <= page;
        end
    end

endmodule

`default_nettype wire

### design/lrupr_checker.sv
// ----------------------------------------------------------------------------
// lrupr_checker
// Port-level checks on the LRU page replacement core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  lrupr_pkg::out_item_t      out_data
);

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Take a reference whenever no result is pending.
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result stage");

    // A new result comes from a reference taken earlier through the input stage and the result register.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result beat without matching reference");

    // A hit needs an earlier miss in the same string.
    a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> out_data.miss_total != '0)
        else $error("hit reported with zero miss count");

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (.*);

`default_nettype wire
